// ===== hdl/ctrb_pkg.sv =====
// shared constants, types and address helper for the console text ring buffer
package ctrb_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int IDX_W       = 12;
    localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int POS_W       = 13;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_LF = 8'd10;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_CR_ISSUE,
        ST_CR_CHECK,
        ST_BS_READ,
        ST_BS_WRITE,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [7:0]       read_char;
        logic [POS_W-1:0] cursor_pos;
        logic [POS_W-1:0] fill_count;
    } result_t;

    // physical cell of a logical position, base below depth, offset at most depth
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] offs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offs);
        if (sum >= SUM_W'(STORE_DEPTH))
        begin
            sum = sum - SUM_W'(STORE_DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

// ===== hdl/console_text_ring_buffer_unit.sv =====
// top level: console text ring buffer with stream ports and output register
// each command runs from exec to done; a read of an index below fill waits for the ram read
// carriage return steps the cursor back one character per ram read until a newline or zero,
// backspace moves each character from the cursor on down one cell, ram read then write
// one item at a time; the next item is taken while a result
// waits in the output register; reset clears oldest pointer, fill and cursor, not the ram
module console_text_ring_buffer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_in [7:0], read_index [19:8], zero [23:20]
    input  logic [0:0]  s_tuser,   // command [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_char [7:0], cursor_pos [20:8], fill_count [33:21]
);
    import ctrb_pkg::*;

    mem_req_t    mem_req;
    result_t     res;
    logic        res_valid;
    logic        out_free;
    logic [7:0]  mem_rdata;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [39:0] m_tdata_reg, m_tdata_next;

    ctrb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser[0]),
        .in_char    (s_tdata[7:0]),
        .in_index   (s_tdata[19:8]),
        .mem_rdata  (mem_rdata),
        .mem_req    (mem_req),
        .res_valid  (res_valid),
        .res        (res),
        .out_free   (out_free)
    );

    ctrb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_free)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
            begin
                m_tdata_next = {6'd0, res.fill_count, res.cursor_pos, res.read_char};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/ctrb_ram.sv =====
// generic single write port, single read port ram with registered read
module ctrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ctrb_ctrl.sv =====
// command sequencer: pointers, fill and cursor, memory walks for cr and backspace
module ctrb_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_command,
    input  logic [7:0]               in_char,
    input  logic [ctrb_pkg::IDX_W-1:0] in_index,
    input  logic [7:0]               mem_rdata,
    output ctrb_pkg::mem_req_t       mem_req,
    output logic                     res_valid,
    output ctrb_pkg::result_t        res,
    input  logic                     out_free
);
    import ctrb_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic              cmd_reg, cmd_next;
    logic [7:0]        char_reg, char_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [7:0]        rchar_reg, rchar_next;

    logic [CNT_W-1:0]  logical;
    logic [ADDR_W-1:0] addr;
    logic              idx_in_fill;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            oldest_reg <= '0;
            fill_reg   <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        char_reg  <= char_next;
        idx_reg   <= idx_next;
        j_reg     <= j_next;
        rchar_reg <= rchar_next;
    end

    assign idx_in_fill = CMP_W'(idx_reg) < CMP_W'(fill_reg);

    // logical position addressed in each state
    always_comb
    begin
        logical = cursor_reg;
        unique case (state_reg)
            ST_EXEC:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    logical = CNT_W'(idx_reg);
                end
                else if (cursor_reg < fill_reg)
                begin
                    logical = cursor_reg;
                end
                else
                begin
                    logical = fill_reg;
                end
            end
            ST_CR_ISSUE: logical = cursor_reg - CNT_W'(1);
            ST_BS_READ:  logical = j_reg + CNT_W'(1);
            ST_BS_WRITE: logical = j_reg;
            default:     logical = cursor_reg;
        endcase
    end

    assign addr = wrap_add(oldest_reg, logical);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        char_next   = char_reg;
        idx_next    = idx_reg;
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        cursor_next = cursor_reg;
        j_next      = j_reg;
        rchar_next  = rchar_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_req     = '0;
        mem_req.waddr = addr;
        mem_req.raddr = addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next   = in_command;
                    char_next  = in_char;
                    idx_next   = in_index;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                rchar_next = 8'd0;
                if (cmd_reg == CMD_READ)
                begin
                    if (idx_in_fill)
                    begin
                        mem_req.re = 1'b1;
                        state_next = ST_RD_WAIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (char_reg == CH_CR)
                begin
                    state_next = ST_CR_ISSUE;
                end
                else if (char_reg == CH_BS)
                begin
                    if (cursor_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        j_next     = cursor_reg - CNT_W'(1);
                        state_next = ST_BS_READ;
                    end
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = char_reg;
                    if (cursor_reg < fill_reg)
                    begin
                        cursor_next = cursor_reg + CNT_W'(1);
                    end
                    else if (fill_reg < DEPTH_CNT)
                    begin
                        fill_next   = fill_reg + CNT_W'(1);
                        cursor_next = fill_reg + CNT_W'(1);
                    end
                    else
                    begin
                        oldest_next = wrap_add(oldest_reg, CNT_W'(1));
                        cursor_next = fill_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_RD_WAIT:
            begin
                rchar_next = mem_rdata;
                state_next = ST_DONE;
            end
            ST_CR_ISSUE:
            begin
                if (cursor_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_req.re = 1'b1;
                    state_next = ST_CR_CHECK;
                end
            end
            ST_CR_CHECK:
            begin
                if (mem_rdata == CH_LF)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cursor_next = cursor_reg - CNT_W'(1);
                    state_next  = ST_CR_ISSUE;
                end
            end
            ST_BS_READ:
            begin
                if ((j_reg + CNT_W'(1)) < fill_reg)
                begin
                    mem_req.re = 1'b1;
                    state_next = ST_BS_WRITE;
                end
                else
                begin
                    fill_next   = fill_reg - CNT_W'(1);
                    cursor_next = cursor_reg - CNT_W'(1);
                    state_next  = ST_DONE;
                end
            end
            ST_BS_WRITE:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = mem_rdata;
                j_next        = j_reg + CNT_W'(1);
                state_next    = ST_BS_READ;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.read_char  = rchar_reg;
    assign res.cursor_pos = POS_W'(cursor_reg);
    assign res.fill_count = POS_W'(fill_reg);

endmodule
